@@ src/frc_pkg.sv @@
`default_nettype none
package frc_pkg;

  localparam int FRAME_BYTES = 32;
  localparam int CHECK_BYTES = 30;
  localparam int POS_W       = 5;
  localparam int WORD_AW     = 4;
  localparam int CH_W        = 4;
  localparam int PULSE_W     = 16;
  localparam int GAP_W       = 16;
  localparam int SYNC_W      = 8;
  localparam int TIME_W      = 32;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 16;

  localparam logic [15:0] CHECK_INIT = 16'hFFFF;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_LIM = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FALLBACK  = 8'd3;

  localparam logic [GAP_W-1:0]   GAP_LIMIT_RST = 16'd3000;
  localparam logic [SYNC_W-1:0]  SYNC_RST      = 8'h20;
  localparam logic [PULSE_W-1:0] PULSE_LIM_RST = 16'd2100;
  localparam logic [PULSE_W-1:0] FALLBACK_RST  = 16'd1000;

  typedef struct packed {
    logic [GAP_W-1:0]   gap_limit_us;
    logic [SYNC_W-1:0]  sync_value;
    logic [PULSE_W-1:0] pulse_limit;
    logic [PULSE_W-1:0] fallback_pulse;
  } cfg_t;

  // frame memory access: one byte-lane write and one word read per cycle
  typedef struct packed {
    logic               we;
    logic               hi;
    logic [WORD_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic               re;
    logic [WORD_AW-1:0] raddr;
  } mem_req_t;

endpackage
`default_nettype wire

@@ src/frc_frame_mem.sv @@
`default_nettype none
module frc_frame_mem (
  input  wire logic            clk_i,
  input  wire frc_pkg::mem_req_t req_i,
  output logic [15:0]          rdata_o
);

  localparam int DEPTH = frc_pkg::FRAME_BYTES / 2;

  logic [1:0][7:0] mem_q [DEPTH];
  logic [15:0]     rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      if (req_i.hi) begin
        mem_q[req_i.waddr][1] <= req_i.wdata;
      end else begin
        mem_q[req_i.waddr][0] <= req_i.wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ src/frc_cfg_regs.sv @@
`default_nettype none
module frc_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           valid_i,
  input  wire logic [frc_pkg::CFG_IDX_W-1:0]  index_i,
  input  wire logic [frc_pkg::CFG_DATA_W-1:0] data_i,
  output frc_pkg::cfg_t                       cfg_o
);

  frc_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gap_limit_us   <= frc_pkg::GAP_LIMIT_RST;
      cfg_q.sync_value     <= frc_pkg::SYNC_RST;
      cfg_q.pulse_limit    <= frc_pkg::PULSE_LIM_RST;
      cfg_q.fallback_pulse <= frc_pkg::FALLBACK_RST;
    end else if (valid_i) begin
      case (index_i)
        frc_pkg::REG_GAP_LIMIT: cfg_q.gap_limit_us   <= data_i[frc_pkg::GAP_W-1:0];
        frc_pkg::REG_SYNC:      cfg_q.sync_value     <= data_i[frc_pkg::SYNC_W-1:0];
        frc_pkg::REG_PULSE_LIM: cfg_q.pulse_limit    <= data_i[frc_pkg::PULSE_W-1:0];
        frc_pkg::REG_FALLBACK:  cfg_q.fallback_pulse <= data_i[frc_pkg::PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

@@ src/ibus_frame_receiver_core.sv @@
`default_nettype none
// Serial-bus frame receiver. Each input transfer carries one received byte and its
// microsecond arrival stamp; a gap above gap_limit_us restarts the frame, and the first
// byte must equal sync_value. Bytes are written into a 16 x 16-bit frame memory as they
// arrive (one per cycle while idle) and the checksum is accumulated on the fly. On the
// 32nd byte a bad checksum goes to an error state that loads one error result (status 1)
// once the output register is free; a good frame reads the channel words from the frame
// memory in turn (read, then load of the output register, which waits out any output
// stall); no input is taken in the meantime. Configuration writes are taken every cycle.
module ibus_frame_receiver_core #(
  parameter int CHANNELS = 14
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // [7:0] byte_value, [39:8] time_us
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // [3:0] channel_index, [19:4] pulse_value, pad
  output logic             m_axis_tuser,  // status
  output logic             m_axis_tlast,  // last_of_frame
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [frc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [frc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ERR,
    ST_READ,
    ST_LOAD
  } state_e;

  state_e state_q;

  frc_pkg::cfg_t    cfg;
  frc_pkg::mem_req_t mem_req;
  logic [15:0]      mem_rdata;

  logic [frc_pkg::POS_W-1:0]   pos_q;
  logic [frc_pkg::TIME_W-1:0]  prev_time_q;
  logic [15:0]                 sum_q;
  logic [7:0]                  rx_lo_q;
  logic [frc_pkg::CH_W-1:0]    ch_q;

  logic                        out_valid_q;
  logic                        out_status_q;
  logic [frc_pkg::CH_W-1:0]    out_ch_q;
  logic [frc_pkg::PULSE_W-1:0] out_pulse_q;
  logic                        out_last_q;

  logic [7:0]                  in_byte;
  logic [frc_pkg::TIME_W-1:0]  in_time;
  logic [frc_pkg::TIME_W-1:0]  gap;
  logic                        restart;
  logic [frc_pkg::POS_W-1:0]   pos_eff;
  logic                        drop;
  logic                        accept;
  logic                        store;
  logic                        frame_end;
  logic                        in_check;
  logic                        check_ok;
  logic                        out_free;
  logic                        out_load;
  logic [frc_pkg::PULSE_W-1:0] pulse;
  logic                        ch_last;

  frc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cfg_valid_i),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  frc_frame_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign cfg_ready_o = 1'b1;

  assign in_byte = s_axis_tdata[7:0];
  assign in_time = s_axis_tdata[39:8];

  // timestamp wraps, so the gap is a plain modular difference
  assign gap       = in_time - prev_time_q;
  assign restart   = gap > {{(frc_pkg::TIME_W - frc_pkg::GAP_W){1'b0}}, cfg.gap_limit_us};
  assign pos_eff   = restart ? '0 : pos_q;
  assign drop      = (pos_eff == '0) && (in_byte != cfg.sync_value);
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign store     = accept && !drop;
  assign frame_end = pos_eff == frc_pkg::POS_W'(frc_pkg::FRAME_BYTES - 1);
  assign in_check  = pos_eff < frc_pkg::POS_W'(frc_pkg::CHECK_BYTES);
  assign check_ok  = sum_q == {in_byte, rx_lo_q};

  assign s_axis_tready = state_q == ST_IDLE;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign out_load      = ((state_q == ST_ERR) || (state_q == ST_LOAD)) && out_free;

  // channel i sits in bytes 2+2i and 3+2i, i.e. memory word i+1
  always_comb begin
    mem_req.we    = store;
    mem_req.hi    = pos_eff[0];
    mem_req.waddr = pos_eff[frc_pkg::POS_W-1:1];
    mem_req.wdata = in_byte;
    mem_req.re    = state_q == ST_READ;
    mem_req.raddr = ch_q + frc_pkg::WORD_AW'(1);
  end

  assign pulse   = (mem_rdata > cfg.pulse_limit) ? cfg.fallback_pulse : mem_rdata;
  assign ch_last = ch_q == frc_pkg::CH_W'(CHANNELS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pos_q        <= '0;
      prev_time_q  <= '0;
      sum_q        <= frc_pkg::CHECK_INIT;
      rx_lo_q      <= '0;
      ch_q         <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= 1'b0;
      out_ch_q     <= '0;
      out_pulse_q  <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            prev_time_q <= in_time;
            // a dropped byte always sits at position zero
            if (drop) begin
              pos_q <= '0;
            end else begin
              if (in_check) begin
                sum_q <= ((pos_eff == '0) ? frc_pkg::CHECK_INIT : sum_q) - {8'd0, in_byte};
              end
              if (pos_eff == frc_pkg::POS_W'(frc_pkg::CHECK_BYTES)) begin
                rx_lo_q <= in_byte;
              end
              if (frame_end) begin
                pos_q <= '0;
                ch_q  <= '0;
                state_q <= check_ok ? ST_READ : ST_ERR;
              end else begin
                pos_q <= pos_eff + frc_pkg::POS_W'(1);
              end
            end
          end
        end
        ST_ERR: begin
          if (out_free) begin
            out_status_q <= 1'b1;
            out_ch_q     <= '0;
            out_pulse_q  <= '0;
            out_last_q   <= 1'b1;
            state_q      <= ST_IDLE;
          end
        end
        ST_READ: begin
          state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          if (out_free) begin
            out_status_q <= 1'b0;
            out_ch_q     <= ch_q;
            out_pulse_q  <= pulse;
            out_last_q   <= ch_last;
            if (ch_last) begin
              state_q <= ST_IDLE;
            end else begin
              ch_q    <= ch_q + frc_pkg::CH_W'(1);
              state_q <= ST_READ;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_pulse_q, out_ch_q};
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire
